/* hw/rtl/pbk_pkg.sv */
// Package for the packed Morse beacon keyer.
// Holds the register indexes, symbol codes and the state/config structs.
// No dependencies.
`timescale 1ns / 1ps

package pbk_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNIT_TICKS    = 2'd0,
        REG_CALL_CODE     = 2'd1,
        REG_MORSE_ENABLED = 2'd2
    } cfg_index_t;

    localparam logic [7:0]  UNIT_TICKS_RST    = 8'd24;
    localparam logic [31:0] CALL_CODE_RST     = 32'd1499005952;
    localparam logic        MORSE_ENABLED_RST = 1'b1;

    // Two-bit symbol codes packed in the call word
    typedef enum logic [1:0] {
        SYM_DOT    = 2'd0,
        SYM_DASH   = 2'd1,
        SYM_LSPACE = 2'd2,
        SYM_WSPACE = 2'd3
    } symbol_t;

    // Phase lengths in units
    localparam logic [2:0] DOT_UNITS    = 3'd1;
    localparam logic [2:0] DASH_UNITS   = 3'd3;
    localparam logic [2:0] LSPACE_UNITS = 3'd2;
    localparam logic [2:0] WSPACE_UNITS = 3'd6;
    localparam logic [2:0] GAP_UNITS    = 3'd1;

    typedef struct packed {
        logic [7:0]  unit_ticks;
        logic [31:0] call_code;
        logic        morse_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0] tick_count;
        logic [2:0] units_left;
        logic       key_phase_on;
        logic [3:0] symbol_index;
        logic       key_level;
    } seq_state_t;

endpackage

/* hw/rtl/pbk_cfg_regs.sv */
// Configuration register file of the beacon keyer.
// Depends on pbk_pkg.
`timescale 1ns / 1ps

module pbk_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pbk_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [pbk_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output pbk_pkg::cfg_t                    cfg
);
    import pbk_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode write index; unknown indexes are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_UNIT_TICKS:    cfg_next.unit_ticks    = cfg_wr_data[7:0];
                REG_CALL_CODE:     cfg_next.call_code     = cfg_wr_data[31:0];
                REG_MORSE_ENABLED: cfg_next.morse_enabled = cfg_wr_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_ticks    <= UNIT_TICKS_RST;
            cfg_reg.call_code     <= CALL_CODE_RST;
            cfg_reg.morse_enabled <= MORSE_ENABLED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/pbk_sequencer.sv */
// Morse symbol sequencer: state registers and the per-tick update.
// Computes key and next symbol position for the tick at the input.
// Depends on pbk_pkg.
`timescale 1ns / 1ps

module pbk_sequencer #(
    parameter int unsigned SYM_COUNT = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pbk_pkg::cfg_t cfg,
    input  logic          tick_en,
    input  logic          run,
    input  logic          carrier_forced,
    output logic          key,
    output logic [3:0]    symbol_position
);
    import pbk_pkg::*;

    localparam logic [4:0] SYM_LAST = 5'(SYM_COUNT);

    seq_state_t seq_reg;
    seq_state_t seq_next;
    logic       was_running_reg;
    logic       was_running_next;

    always_comb begin
        seq_state_t s;
        logic       active;
        logic [4:0] idx_inc;
        symbol_t    sym;
        logic [7:0] limit;
        logic [7:0] tc_inc;

        active = run && cfg.morse_enabled && !carrier_forced;

        // Rising run restarts the call
        s = seq_reg;
        if (run && !was_running_reg) begin
            s = '0;
        end

        // Fetch the next symbol when the current phase is done
        sym     = symbol_t'(cfg.call_code[5'd30 - {s.symbol_index, 1'b0} +: 2]);
        idx_inc = {1'b0, s.symbol_index} + 5'd1;
        if (active && s.units_left == 3'd0) begin
            s.tick_count = 8'd0;
            s.symbol_index = (idx_inc >= SYM_LAST) ? 4'd0 : idx_inc[3:0];
            unique case (sym)
                SYM_DOT: begin
                    s.key_level = 1'b1; s.key_phase_on = 1'b1; s.units_left = DOT_UNITS;
                end
                SYM_DASH: begin
                    s.key_level = 1'b1; s.key_phase_on = 1'b1; s.units_left = DASH_UNITS;
                end
                SYM_LSPACE: begin
                    s.key_level = 1'b0; s.key_phase_on = 1'b0; s.units_left = LSPACE_UNITS;
                end
                default: begin
                    s.key_level = 1'b0; s.key_phase_on = 1'b0; s.units_left = WSPACE_UNITS;
                    s.symbol_index = 4'd0;
                end
            endcase
        end

        // Key priority: forced carrier, then run, then steady carrier
        if (carrier_forced) begin
            key = 1'b1;
        end else if (!run) begin
            key = 1'b0;
        end else if (!cfg.morse_enabled) begin
            key = 1'b1;
        end else begin
            key = s.key_level;
        end
        symbol_position = s.symbol_index;

        // Count the tick; a zero unit length counts as one tick
        limit  = (cfg.unit_ticks == 8'd0) ? 8'd1 : cfg.unit_ticks;
        tc_inc = s.tick_count + 8'd1;
        if (active) begin
            s.tick_count = tc_inc;
            if (tc_inc >= limit || tc_inc == 8'd0) begin
                s.tick_count = 8'd0;
                if (s.units_left != 3'd0) begin
                    s.units_left = s.units_left - 3'd1;
                end
                // End of keyed phase: one unit of gap follows
                if (s.units_left == 3'd0 && s.key_phase_on) begin
                    s.key_phase_on = 1'b0;
                    s.key_level    = 1'b0;
                    s.units_left   = GAP_UNITS;
                end
            end
        end

        seq_next         = tick_en ? s : seq_reg;
        was_running_next = tick_en ? run : was_running_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg         <= '0;
            was_running_reg <= 1'b0;
        end else begin
            seq_reg         <= seq_next;
            was_running_reg <= was_running_next;
        end
    end

endmodule

/* hw/rtl/packed_morse_beacon_keyer.sv */
// Top level of the packed Morse beacon keyer.
// Depends on pbk_pkg, pbk_cfg_regs and pbk_sequencer.
//
// Each input transaction is one timer tick and yields exactly one result
// transaction (key, symbol_position). The block takes one tick per clock
// cycle unless the output stalls; the result is loaded into the output
// register at the edge that accepts the tick. The sequencer state and the
// output register are both updated at the accepting edge, so the rate is set
// by that single register stage and the input stays ready while the output
// register is empty or being taken. Configuration writes take effect at the
// next edge and should be made while no result is pending. CODE_BYTES (1..8)
// sets the call length to CODE_BYTES*4 symbols, capped at 16.
`timescale 1ns / 1ps

module packed_morse_beacon_keyer #(
    parameter int unsigned CODE_BYTES = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pbk_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [pbk_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_run,
    input  logic                           s_carrier_forced,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_key,
    output logic [3:0]                     m_symbol_position
);
    import pbk_pkg::*;

    localparam int unsigned SYM_COUNT = (CODE_BYTES * 4 > 16) ? 16 :
                                        (CODE_BYTES * 4 < 1)  ? 1  : CODE_BYTES * 4;

    cfg_t       cfg;
    logic       tick_en;
    logic       key;
    logic [3:0] symbol_position;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic       m_key_reg;
    logic [3:0] m_symbol_position_reg;

    pbk_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    pbk_sequencer #(
        .SYM_COUNT (SYM_COUNT)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .tick_en         (tick_en),
        .run             (s_run),
        .carrier_forced  (s_carrier_forced),
        .key             (key),
        .symbol_position (symbol_position)
    );

    // Accept while the output register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign tick_en = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (tick_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded on each accepted transaction
    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_key_reg             <= key;
            m_symbol_position_reg <= symbol_position;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_key             = m_key_reg;
    assign m_symbol_position = m_symbol_position_reg;

endmodule

/* hw/rtl/pbk_checker.sv */
// Port-level checks for the packed Morse beacon keyer, bound to the top.
// Depends on packed_morse_beacon_keyer and pbk_pkg.
`timescale 1ns / 1ps

module pbk_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [pbk_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input logic [pbk_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_run,
    input logic                           s_carrier_forced,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_key,
    input logic [3:0]                     m_symbol_position
);
    import pbk_pkg::*;

    logic unused_cfg;
    assign unused_cfg = cfg_wr_en ^ (^cfg_wr_index) ^ (^cfg_wr_data) ^ (^m_symbol_position);

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // Empty output register must leave the input open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Forced carrier always keys
    a_forced_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_carrier_forced |=> m_valid && m_key)
        else $error("forced carrier did not key");

    // Not running and not forced keeps the key off
    a_idle_key_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_run && !s_carrier_forced |=> m_valid && !m_key)
        else $error("key on while not running");

    // A stalled result stays
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

endmodule

bind packed_morse_beacon_keyer pbk_checker u_pbk_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_index      (cfg_wr_index),
    .cfg_wr_data       (cfg_wr_data),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_run             (s_run),
    .s_carrier_forced  (s_carrier_forced),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_key             (m_key),
    .m_symbol_position (m_symbol_position)
);
